// ===== rtl/obb_pkg.sv =====
// Package for the oriented-box overlap test.
// Holds widths, the guard reset value and register indexes. No dependencies.
package obb_pkg;
  localparam int COMPONENT_WIDTH = 16;
  localparam int GUARD_WIDTH = 10;
  localparam logic [9:0] GUARD_RESET = 10'd16;
  localparam int ADDR_WIDTH = 2;
  localparam logic [ADDR_WIDTH-1:0] REG_PARALLEL_GUARD = 2'd0;
endpackage

// ===== rtl/obb_if.sv =====
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
interface obb_if #(parameter int W = 1) ();
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/obb_prod.sv =====
// Stages 1-2: matrix R, offset t in frame A, abs R plus guard.
// Uses obb_pkg.
module obb_prod #(
  parameter int CW = obb_pkg::COMPONENT_WIDTH
) (
  input  logic clk,
  input  logic en,
  input  logic [3*CW-1:0] ca, cb, ea, eb,
  input  logic [3*CW-1:0] a0, a1, a2, b0, b1, b2,
  input  logic [obb_pkg::GUARD_WIDTH-1:0] guard,
  output logic signed [2*CW+2:0] r [3][3],
  output logic signed [2*CW+2:0] ar [3][3],
  output logic signed [2*CW+3:0] t [3],
  output logic [CW-1:0] ea_o [3],
  output logic [CW-1:0] eb_o [3]
);
  localparam int GUARD_WIDTH_L = obb_pkg::GUARD_WIDTH;

  logic signed [CW-1:0] au [3][3];
  logic signed [CW-1:0] bu [3][3];
  logic signed [CW:0] d [3];
  logic signed [2*CW-1:0] pr [3][3][3];
  logic signed [2*CW:0] pt [3][3];
  logic [CW-1:0] ea1 [3];
  logic [CW-1:0] eb1 [3];
  logic [GUARD_WIDTH_L-1:0] g1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      au[0][k] = a0[k*CW +: CW];
      au[1][k] = a1[k*CW +: CW];
      au[2][k] = a2[k*CW +: CW];
      bu[0][k] = b0[k*CW +: CW];
      bu[1][k] = b1[k*CW +: CW];
      bu[2][k] = b2[k*CW +: CW];
      d[k] = (CW+1)'($signed(cb[k*CW +: CW])) - (CW+1)'($signed(ca[k*CW +: CW]));
    end
  end

  // stage 1: all products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          pt[i][k] <= d[k] * au[i][k];
          for (int j = 0; j < 3; j++) pr[i][j][k] <= au[i][k] * bu[j][k];
        end
        ea1[i] <= ea[i*CW +: CW];
        eb1[i] <= eb[i*CW +: CW];
      end
      g1 <= guard;
    end
  end

  // stage 2: sums, abs plus guard
  always_ff @(posedge clk) begin
    logic signed [2*CW+2:0] s;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t[i] <= (2*CW+4)'(pt[i][0]) + (2*CW+4)'(pt[i][1]) + (2*CW+4)'(pt[i][2]);
        for (int j = 0; j < 3; j++) begin
          s = (2*CW+3)'(pr[i][j][0]) + (2*CW+3)'(pr[i][j][1]) + (2*CW+3)'(pr[i][j][2]);
          r[i][j] <= s;
          ar[i][j] <= (s < 0 ? -s : s) + ((2*CW+3)'(g1) <<< (CW-2));
        end
        ea_o[i] <= ea1[i];
        eb_o[i] <= eb1[i];
      end
    end
  end
endmodule

// ===== rtl/obb_axes.sv =====
// Stages 3-5: projections on the 15 axes and the compare.
// Uses obb_pkg.
module obb_axes #(
  parameter int CW = obb_pkg::COMPONENT_WIDTH
) (
  input  logic clk,
  input  logic en,
  input  logic signed [2*CW+2:0] r [3][3],
  input  logic signed [2*CW+2:0] ar [3][3],
  input  logic signed [2*CW+3:0] t [3],
  input  logic [CW-1:0] ea [3],
  input  logic [CW-1:0] eb [3],
  output logic overlap
);
  localparam int PW = 3*CW + 5;   // extent times abs R
  localparam int TW = 4*CW + 7;   // offset times R
  localparam int XW = 6*CW + 12;  // compare width
  localparam int AF = CW - 2;

  logic signed [PW-1:0] pea [3][3][3];  // ea[m]*ar[n][j]
  logic signed [PW-1:0] peb [3][3][3];  // eb[m]*ar[n][j]
  logic signed [TW-1:0] ptr [3][3][3];  // t[m]*r[n][j]
  logic signed [CW+1:0] ea3 [3];
  logic signed [CW+1:0] eb3 [3];
  logic signed [2*CW+4:0] t3 [3];
  logic [14:0] sep;

  // stage 3: products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < 3; m++) begin
        for (int n = 0; n < 3; n++) begin
          for (int j = 0; j < 3; j++) begin
            pea[m][n][j] <= $signed({1'b0, ea[m]}) * ar[n][j];
            peb[m][n][j] <= $signed({1'b0, eb[m]}) * ar[n][j];
            ptr[m][n][j] <= t[m] * r[n][j];
          end
        end
        ea3[m] <= (CW+2)'($signed({1'b0, ea[m]}));
        eb3[m] <= (CW+2)'($signed({1'b0, eb[m]}));
        t3[m] <= (2*CW+5)'(t[m]);
      end
    end
  end

  // stage 4: sums and per-axis compares
  always_ff @(posedge clk) begin
    logic signed [XW-1:0] lhs, rhs, s;
    integer i1, i2, j1, j2;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        // face of A
        s = XW'(peb[0][i][0]) + XW'(peb[1][i][1]) + XW'(peb[2][i][2]);
        rhs = (XW'(ea3[i]) <<< (3*AF)) + (s <<< AF);
        lhs = XW'(t3[i] < 0 ? -t3[i] : t3[i]) <<< (2*AF);
        sep[i] <= lhs > rhs;
        // face of B
        s = XW'(pea[0][0][i]) + XW'(pea[1][1][i]) + XW'(pea[2][2][i]);
        rhs = (s <<< AF) + (XW'(eb3[i]) <<< (3*AF));
        lhs = XW'(ptr[0][0][i]) + XW'(ptr[1][1][i]) + XW'(ptr[2][2][i]);
        lhs = lhs < 0 ? -lhs : lhs;
        sep[3+i] <= lhs > rhs;
      end
      for (int i = 0; i < 3; i++) begin
        i1 = (i + 1) % 3;
        i2 = (i + 2) % 3;
        for (int j = 0; j < 3; j++) begin
          j1 = (j + 1) % 3;
          j2 = (j + 2) % 3;
          rhs = XW'(pea[i1][i2][j]) + XW'(pea[i2][i1][j])
              + XW'(peb[j1][i][j2]) + XW'(peb[j2][i][j1]);
          rhs = rhs <<< AF;
          lhs = XW'(ptr[i2][i1][j]) - XW'(ptr[i1][i2][j]);
          lhs = lhs < 0 ? -lhs : lhs;
          sep[6 + 3*i + j] <= lhs > rhs;
        end
      end
    end
  end

  // stage 5: combine
  always_ff @(posedge clk) begin
    if (en) overlap <= ~|sep;
  end
endmodule

// ===== rtl/obb_obb_overlap_test.sv =====
// Top level of the oriented-box overlap test: APB register, pipeline control.
// Uses obb_pkg, obb_if, obb_prod, obb_axes.
//
// Usage:
//  in channel (obb_if sink) carries both boxes as ten 3*COMPONENT_WIDTH-bit fields, x low.
//  out channel (obb_if source) carries one overlap bit per input beat:
//  1 when no separating axis is found among the 15 candidate axes.
//  APB port writes parallel_guard at address 0 (reset 16), reads it back.
// Throughput: one beat per cycle unless stalled; every stage is a register stage
// and the whole pipeline advances together.
// Stall: when out.ready is low and the last stage holds a beat, the whole
// pipeline freezes, bubbles included; in.ready falls so nothing is lost or
// repeated.
// Reset: rst (synchronous) clears all valid bits and sets the guard to 16.
//
module obb_obb_overlap_test #(
  parameter int COMPONENT_WIDTH = obb_pkg::COMPONENT_WIDTH
) (
  input  logic clk,
  input  logic rst,
  obb_if.sink in,
  obb_if.source out,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [obb_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int CW = COMPONENT_WIDTH;
  localparam int FW = 3*CW;
  localparam int STAGES = 5;

  logic [obb_pkg::GUARD_WIDTH-1:0] guard;
  logic [STAGES-1:0] vld;
  logic en;
  logic signed [2*CW+2:0] r [3][3];
  logic signed [2*CW+2:0] ar [3][3];
  logic signed [2*CW+3:0] t [3];
  logic [CW-1:0] ea [3];
  logic [CW-1:0] eb [3];

  // config register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      guard <= obb_pkg::GUARD_RESET;
    end else if (psel && penable && pwrite && paddr == obb_pkg::REG_PARALLEL_GUARD) begin
      guard <= pwdata[obb_pkg::GUARD_WIDTH-1:0];
    end
  end
  assign prdata = (paddr == obb_pkg::REG_PARALLEL_GUARD)
                ? {{(32-obb_pkg::GUARD_WIDTH){1'b0}}, guard} : 32'd0;

  // pipeline advance
  assign en = out.ready || !vld[STAGES-1];
  assign in.ready = en;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in.valid};
    end
  end
  assign out.valid = vld[STAGES-1];

  obb_prod #(.CW(CW)) u_prod (
    .clk(clk), .en(en),
    .ca(in.data[0*FW +: FW]), .a0(in.data[1*FW +: FW]), .a1(in.data[2*FW +: FW]),
    .a2(in.data[3*FW +: FW]), .ea(in.data[4*FW +: FW]), .cb(in.data[5*FW +: FW]),
    .b0(in.data[6*FW +: FW]), .b1(in.data[7*FW +: FW]), .b2(in.data[8*FW +: FW]),
    .eb(in.data[9*FW +: FW]), .guard(guard),
    .r(r), .ar(ar), .t(t), .ea_o(ea), .eb_o(eb)
  );

  obb_axes #(.CW(CW)) u_axes (
    .clk(clk), .en(en), .r(r), .ar(ar), .t(t), .ea(ea), .eb(eb),
    .overlap(out.data[0])
  );
endmodule

// ===== tb/sv/obb_obb_overlap_test_tb.sv =====
// Testbench for the oriented-box overlap test: box-pair beats in, overlap bits out.
// It predicts each overlap bit on its own and checks the output stream against it.
// Depends on obb_pkg, obb_if and the obb_obb_overlap_test RTL.
`timescale 1ns / 100ps

module obb_obb_overlap_test_tb;
  localparam int CW = obb_pkg::COMPONENT_WIDTH;
  localparam int FW = 3 * CW;
  localparam int BW = 10 * FW;
  localparam int AFRAC = CW - 2;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [15:0] UNIT = 16'sd16384;

  typedef logic signed [127:0] wide_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [obb_pkg::ADDR_WIDTH-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  obb_if #(.W(BW)) in_if ();
  obb_if #(.W(1)) out_if ();

  obb_obb_overlap_test u_dut (
    .clk(clk), .rst(rst), .in(in_if), .out(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // expected overlap bits, oldest first
  logic overlap_queue[$];
  logic [obb_pkg::GUARD_WIDTH-1:0] guard_shadow = obb_pkg::GUARD_RESET;
  int error_count = 0;
  int idle_cycles = 0;
  bit send_gaps = 1'b0;
  bit sink_stalls = 1'b0;
  int hold_request = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic wide_t wabs(input wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // Separating-axis test on 15 axes at full width
  function automatic logic pair_overlaps(input logic [BW-1:0] b,
                                         input logic [obb_pkg::GUARD_WIDTH-1:0] g);
    wide_t au[3][3], bu[3][3], ea[3], eb[3], d[3], t[3], r[3][3], ar[3][3];
    wide_t guard, ra, rb, rhs, lhs;
    int i1, i2, j1, j2;
    logic sep;
    sep = 1'b0;
    guard = {118'd0, g};
    guard = guard <<< AFRAC;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        au[i][k] = $signed(b[(1 + i) * FW + k * CW +: CW]);
        bu[i][k] = $signed(b[(6 + i) * FW + k * CW +: CW]);
      end
      ea[k] = {112'd0, b[4 * FW + k * CW +: CW]};
      eb[k] = {112'd0, b[9 * FW + k * CW +: CW]};
      d[k] = $signed(b[5 * FW + k * CW +: CW]) - $signed(b[k * CW +: CW]);
    end
    for (int i = 0; i < 3; i++) begin
      t[i] = d[0] * au[i][0] + d[1] * au[i][1] + d[2] * au[i][2];
      for (int j = 0; j < 3; j++) begin
        r[i][j] = au[i][0] * bu[j][0] + au[i][1] * bu[j][1] + au[i][2] * bu[j][2];
        ar[i][j] = wabs(r[i][j]) + guard;
      end
    end
    // face axes of A, then of B
    for (int i = 0; i < 3; i++) begin
      rb = eb[0] * ar[i][0] + eb[1] * ar[i][1] + eb[2] * ar[i][2];
      rhs = (ea[i] <<< (3 * AFRAC)) + (rb <<< AFRAC);
      lhs = wabs(t[i]) <<< (2 * AFRAC);
      if (lhs > rhs) sep = 1'b1;
      ra = ea[0] * ar[0][i] + ea[1] * ar[1][i] + ea[2] * ar[2][i];
      rhs = (ra <<< AFRAC) + (eb[i] <<< (3 * AFRAC));
      lhs = wabs(t[0] * r[0][i] + t[1] * r[1][i] + t[2] * r[2][i]);
      if (lhs > rhs) sep = 1'b1;
    end
    // edge cross products
    for (int i = 0; i < 3; i++) begin
      i1 = (i + 1) % 3;
      i2 = (i + 2) % 3;
      for (int j = 0; j < 3; j++) begin
        j1 = (j + 1) % 3;
        j2 = (j + 2) % 3;
        ra = ea[i1] * ar[i2][j] + ea[i2] * ar[i1][j];
        rb = eb[j1] * ar[i][j2] + eb[j2] * ar[i][j1];
        rhs = (ra + rb) <<< AFRAC;
        lhs = wabs(t[i2] * r[i1][j] - t[i1] * r[i2][j]);
        if (lhs > rhs) sep = 1'b1;
      end
    end
    return !sep;
  endfunction

  function automatic logic [FW-1:0] pack3(input logic [15:0] x, input logic [15:0] y,
                                          input logic [15:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [15:0] rand_signed(input int span);
    return 16'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // three axes of one box: signed permutation, perturbed one, or arbitrary
  function automatic logic [3*FW-1:0] rand_axes();
    logic [15:0] m[3][3];
    int p, mode;
    mode = $urandom_range(0, 2);
    p = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) begin
        if (mode == 2) m[i][k] = rand_signed(20000);
        else begin
          m[i][k] = (k == (i + p) % 3) ? (($urandom & 1) ? UNIT : -UNIT) : 16'd0;
          if (mode == 1) m[i][k] = m[i][k] + rand_signed(3000);
        end
      end
    return {pack3(m[2][0], m[2][1], m[2][2]), pack3(m[1][0], m[1][1], m[1][2]),
            pack3(m[0][0], m[0][1], m[0][2])};
  endfunction

  function automatic logic [BW-1:0] rand_pair();
    logic [BW-1:0] b;
    int span;
    if ($urandom_range(0, 9) == 0) begin
      for (int w = 0; w < BW / 32; w++) b[w * 32 +: 32] = $urandom;
      return b;
    end
    span = ($urandom & 1) ? 1500 : 6000;
    b[0 +: FW] = pack3(rand_signed(span), rand_signed(span), rand_signed(span));
    b[FW +: 3 * FW] = rand_axes();
    b[4 * FW +: FW] = pack3(16'($urandom_range(0, 2500)), 16'($urandom_range(0, 2500)),
                            16'($urandom_range(0, 2500)));
    b[5 * FW +: FW] = pack3(rand_signed(span), rand_signed(span), rand_signed(span));
    b[6 * FW +: 3 * FW] = rand_axes();
    b[9 * FW +: FW] = pack3(16'($urandom_range(0, 2500)), 16'($urandom_range(0, 2500)),
                            16'($urandom_range(0, 2500)));
    return b;
  endfunction

  function automatic logic [BW-1:0] aligned_pair(input logic [15:0] dx,
                                                 input logic [15:0] ext);
    logic [BW-1:0] b;
    b[0 +: FW] = '0;
    b[FW +: FW] = pack3(UNIT, 16'd0, 16'd0);
    b[2 * FW +: FW] = pack3(16'd0, UNIT, 16'd0);
    b[3 * FW +: FW] = pack3(16'd0, 16'd0, UNIT);
    b[4 * FW +: FW] = pack3(ext, ext, ext);
    b[5 * FW +: FW] = pack3(dx, 16'd0, 16'd0);
    b[6 * FW +: 3 * FW] = b[FW +: 3 * FW];
    b[9 * FW +: FW] = pack3(ext, ext, ext);
    return b;
  endfunction

  // input side: record what each accepted beat should produce
  always @(posedge clk) begin
    if (!rst && in_if.valid && in_if.ready)
      overlap_queue.push_back(pair_overlaps(in_if.data, guard_shadow));
  end

  // output side: compare each accepted beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) begin
      if (overlap_queue.size() == 0) begin
        $display("%0t: unexpected overlap beat, expected none actual %0b", $time,
                 out_if.data[0]);
        error_count++;
      end else begin
        if (out_if.data[0] !== overlap_queue[0]) begin
          $display("%0t: overlap mismatch, expected %0b actual %0b", $time,
                   overlap_queue[0], out_if.data[0]);
          error_count++;
        end
        void'(overlap_queue.pop_front());
      end
    end
  end

  // receiver: random stall bursts, or one long hold-off on request
  always begin
    @(posedge clk);
    if (hold_request > 0) begin
      out_if.ready <= 1'b0;
      repeat (hold_request) @(posedge clk);
      hold_request = 0;
      out_if.ready <= 1'b1;
    end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
      out_if.ready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || rst)
      idle_cycles <= 0;
    else if (overlap_queue.size() != 0 || in_if.valid) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_pair(input logic [BW-1:0] b);
    in_if.valid <= 1'b1;
    in_if.data <= b;
    do @(posedge clk); while (!in_if.ready);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (overlap_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_guard(input logic [obb_pkg::GUARD_WIDTH-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= obb_pkg::REG_PARALLEL_GUARD;
    pwdata <= {$urandom} << obb_pkg::GUARD_WIDTH | value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    guard_shadow = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_guard_readback();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= obb_pkg::REG_PARALLEL_GUARD;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[obb_pkg::GUARD_WIDTH-1:0] !== guard_shadow) begin
      $display("%0t: guard readback mismatch, expected %0d actual %0d", $time,
               guard_shadow, prdata[obb_pkg::GUARD_WIDTH-1:0]);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // extremes, touching faces, unsigned extents, odd axes, then eight random pairs
  task automatic test_directed();
    logic [BW-1:0] b;
    send_pair('0);
    send_pair('1);
    send_pair(aligned_pair(16'd512, 16'd256));
    send_pair(aligned_pair(16'd513, 16'd256));
    send_pair(aligned_pair(16'd600, 16'd256));
    send_pair(aligned_pair(16'h7fff, 16'd256));
    send_pair(aligned_pair(16'h8000, 16'hffff));
    send_pair(aligned_pair(16'h7fff, 16'h8000));
    b = aligned_pair(16'd3000, 16'd100);
    b[FW +: 3 * FW] = {pack3(16'd0, 16'd0, 16'h7fff), pack3(16'd0, 16'h8000, 16'd0),
                       pack3(16'h7fff, 16'd0, 16'd0)};
    send_pair(b);
    b[6 * FW +: 3 * FW] = {3{pack3(16'h4000, 16'h4000, 16'h4000)}};
    send_pair(b);
    b = '1;
    b[4 * FW +: FW] = '0;
    b[9 * FW +: FW] = '0;
    send_pair(b);
    b = '0;
    b[5 * FW +: FW] = pack3(16'h7fff, 16'h7fff, 16'h7fff);
    b[FW +: FW] = pack3(16'h7fff, 16'h7fff, 16'h7fff);
    b[6 * FW +: FW] = pack3(16'h8000, 16'h8000, 16'h8000);
    send_pair(b);
    for (int n = 0; n < 8; n++) send_pair(rand_pair());
    stop_sending();
    drain();
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) send_pair(rand_pair());
    stop_sending();
    drain();
  endtask

  // receiver holds off long while the sender keeps offering beats
  task automatic test_backpressure();
    bit gaps_saved;
    gaps_saved = send_gaps;
    send_gaps = 1'b0;
    hold_request = 300;
    for (int n = 0; n < 40; n++) send_pair(rand_pair());
    stop_sending();
    drain();
    send_gaps = gaps_saved;
  endtask

  task automatic test_guard_settings();
    logic [obb_pkg::GUARD_WIDTH-1:0] settings[4];
    settings = '{10'd0, 10'd1023, 10'($urandom_range(1, 1022)), obb_pkg::GUARD_RESET};
    foreach (settings[s]) begin
      write_guard(settings[s]);
      check_guard_readback();
      test_random(150);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_guard_readback();
    test_directed();
    send_gaps = 1'b1;
    sink_stalls = 1'b1;
    test_random(600);
    test_backpressure();
    test_guard_settings();
    // closing stretch at full rate
    send_gaps = 1'b0;
    sink_stalls = 1'b0;
    test_random(540);
    if (error_count == 0 && overlap_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/obb_pkg.sv
rtl/obb_if.sv
rtl/obb_prod.sv
rtl/obb_axes.sv
rtl/obb_obb_overlap_test.sv
tb/sv/obb_obb_overlap_test_tb.sv
